// File: rtl/esfm_pkg.sv
`default_nettype none

package esfm_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int COL_W             = 12;
    localparam int CFG_W             = 13;
    localparam int HALF_WINDOW       = 8;
    localparam int HIST_DEPTH        = 2 * HALF_WINDOW - 1;
    localparam int MARGIN_EXTRA      = 10;
    localparam int MIN_LINE_LENGTH   = 37;
    localparam int LINE_LENGTH_RESET = 1024;

    // a + c runs from 1 to 2*HALF_WINDOW-2
    localparam int NUM_SUMS = 2 * HALF_WINDOW - 2;

    // width of the counter of trailing columns flushed after the final sample of a line
    localparam int FLUSH_W = $clog2(HALF_WINDOW);

    localparam int TDATA_W = ((COL_W + SAMPLE_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - COL_W - SAMPLE_W;

    // floor(x/d) = (x * (floor(2^24/d) + 1)) >> 24, exact for 16-bit x and d <= 14
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SAMPLE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP [NUM_SUMS] = '{
        RECIP_ONE / 1  + RECIP_W'(1),
        RECIP_ONE / 2  + RECIP_W'(1),
        RECIP_ONE / 3  + RECIP_W'(1),
        RECIP_ONE / 4  + RECIP_W'(1),
        RECIP_ONE / 5  + RECIP_W'(1),
        RECIP_ONE / 6  + RECIP_W'(1),
        RECIP_ONE / 7  + RECIP_W'(1),
        RECIP_ONE / 8  + RECIP_W'(1),
        RECIP_ONE / 9  + RECIP_W'(1),
        RECIP_ONE / 10 + RECIP_W'(1),
        RECIP_ONE / 11 + RECIP_W'(1),
        RECIP_ONE / 12 + RECIP_W'(1),
        RECIP_ONE / 13 + RECIP_W'(1),
        RECIP_ONE / 14 + RECIP_W'(1)
    };

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [COL_W-1:0]    col_t;

    // per-sample control carried down the pipeline
    typedef struct packed {
        logic emit;       // sample completes a column result
        logic line_done;  // final sample of the line
        logic win;        // column lies inside the measured span
        col_t col;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/edge_slope_focus_metric.sv
// Edge slope focus metric over a column brightness profile.
//
// Slave stream: one unsigned Q8.8 brightness word per column on s_tdata.
// Master stream: one word per column, carrying the column index and the largest
// slope floor(|b[p+a]-b[p-c]|/(a+c)) (a = 0..7, c = 1..7) around that column.
// Columns within 18 of either line end report zero; m_tlast marks a line's last word.
// cfg_wr_en/cfg_wr_data load the line length (saturated to 37..MAX_LINE_LENGTH);
// write it only while the block is idle.
//
// Throughput is one sample word per cycle while m_tready is high and no line tail is
// draining. Column p leaves with sample p+7; the first seven samples of a line give
// no word. The final sample of a line yields eight words (its own column plus seven
// zero columns), drained one per cycle while m_tready is high by the output sequencer,
// which holds the input side while it drains them. A sample loads the window register
// at the accepting edge, then passes the slope, divide and output registers to m_tvalid.
//
// Reset clears the sample history, the column counter and all valid flags and loads
// a line length of 1024. When m_tready is low the output word holds; each stage
// keeps accepting until its own register is full, then backpressure reaches s_tready.
`default_nettype none

module edge_slope_focus_metric #(
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [esfm_pkg::CFG_W-1:0]    cfg_wr_data,   // line_length
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [esfm_pkg::SAMPLE_W-1:0] s_tdata,       // [15:0] sample
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [esfm_pkg::TDATA_W-1:0]       m_tdata,       // [11:0] column, [27:12] focus
    output logic                               m_tlast        // line_end
);

    logic              win_valid, win_ready;
    logic              slope_valid, slope_ready;
    logic              div_valid, div_ready;
    esfm_pkg::sample_t hist  [esfm_pkg::HIST_DEPTH];
    esfm_pkg::sample_t peak  [esfm_pkg::NUM_SUMS];
    esfm_pkg::sample_t quot  [esfm_pkg::NUM_SUMS];
    esfm_pkg::tok_t    win_tok, slope_tok, div_tok;
    esfm_pkg::col_t    out_col;
    esfm_pkg::sample_t out_focus;

    // hold the sample history and column count; tag each sample
    esfm_window #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   (s_tdata),
        .out_valid   (win_valid),
        .out_ready   (win_ready),
        .hist        (hist),
        .tok         (win_tok)
    );

    // largest brightness step for each span a+c
    esfm_slope u_slope (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .hist      (hist),
        .in_tok    (win_tok),
        .out_valid (slope_valid),
        .out_ready (slope_ready),
        .peak      (peak),
        .out_tok   (slope_tok)
    );

    // scale each step by its span
    esfm_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slope_valid),
        .in_ready  (slope_ready),
        .peak      (peak),
        .in_tok    (slope_tok),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quot      (quot),
        .out_tok   (div_tok)
    );

    // pick the maximum, apply the margins, flush the line tail
    esfm_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .quot      (quot),
        .in_tok    (div_tok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_col   (out_col),
        .out_focus (out_focus),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{esfm_pkg::PAD_W{1'b0}}, out_focus, out_col};

endmodule

`default_nettype wire

// File: rtl/esfm_window.sv
`default_nettype none

module esfm_window #(
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [esfm_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire esfm_pkg::sample_t         in_sample,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output esfm_pkg::sample_t              hist [esfm_pkg::HIST_DEPTH],
    output esfm_pkg::tok_t                 tok
);

    localparam int CNT_W = $clog2(MAX_LINE_LENGTH);
    localparam int LEN_W = (CNT_W + 1 > esfm_pkg::CFG_W) ? CNT_W + 1 : esfm_pkg::CFG_W;

    logic [esfm_pkg::CFG_W-1:0] line_length_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       valid_reg, valid_next;
    esfm_pkg::sample_t          hist_reg [esfm_pkg::HIST_DEPTH];
    esfm_pkg::tok_t             tok_reg, tok_next;

    logic             accept;
    logic [LEN_W-1:0] len_raw, len_eff, n_ext, p_full;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign tok       = tok_reg;

    always_comb
    begin
        for (int i = 0; i < esfm_pkg::HIST_DEPTH; i++)
        begin
            hist[i] = hist_reg[i];
        end
    end

    // saturate the programmed length
    always_comb
    begin
        len_raw = LEN_W'(line_length_reg);
        if (len_raw < LEN_W'(esfm_pkg::MIN_LINE_LENGTH))
        begin
            len_eff = LEN_W'(esfm_pkg::MIN_LINE_LENGTH);
        end
        else if (len_raw > LEN_W'(MAX_LINE_LENGTH))
        begin
            len_eff = LEN_W'(MAX_LINE_LENGTH);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    always_comb
    begin
        n_ext  = LEN_W'(count_reg);
        p_full = n_ext - LEN_W'(esfm_pkg::HALF_WINDOW - 1);

        tok_next.emit      = n_ext >= LEN_W'(esfm_pkg::HALF_WINDOW - 1);
        tok_next.line_done = n_ext >= len_eff - LEN_W'(1);
        tok_next.win       = (n_ext >= LEN_W'(2 * esfm_pkg::HALF_WINDOW
                                               + esfm_pkg::MARGIN_EXTRA - 1))
                          && (n_ext + LEN_W'(esfm_pkg::MARGIN_EXTRA + 1) < len_eff);
        tok_next.col       = p_full[esfm_pkg::COL_W-1:0];

        count_next = tok_next.line_done ? '0 : count_reg + CNT_W'(1);

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= esfm_pkg::CFG_W'(esfm_pkg::LINE_LENGTH_RESET);
            count_reg       <= '0;
            valid_reg       <= 1'b0;
            tok_reg         <= '0;
            for (int i = 0; i < esfm_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                line_length_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                count_reg   <= count_next;
                tok_reg     <= tok_next;
                hist_reg[0] <= in_sample;
                for (int i = 1; i < esfm_pkg::HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/esfm_slope.sv
`default_nettype none

module esfm_slope (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire esfm_pkg::sample_t hist [esfm_pkg::HIST_DEPTH],
    input  wire esfm_pkg::tok_t    in_tok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output esfm_pkg::sample_t      peak [esfm_pkg::NUM_SUMS],
    output esfm_pkg::tok_t         out_tok
);

    logic              valid_reg, valid_next;
    esfm_pkg::sample_t peak_reg  [esfm_pkg::NUM_SUMS];
    esfm_pkg::sample_t peak_next [esfm_pkg::NUM_SUMS];
    esfm_pkg::tok_t    tok_reg;
    logic              take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    // largest |b[p+a] - b[p-c]| for each distance a+c; the divisor is shared per distance
    always_comb
    begin
        esfm_pkg::sample_t lead, trail, diff;
        for (int s = 0; s < esfm_pkg::NUM_SUMS; s++)
        begin
            peak_next[s] = '0;
        end
        for (int a = 0; a < esfm_pkg::HALF_WINDOW; a++)
        begin
            for (int c = 1; c < esfm_pkg::HALF_WINDOW; c++)
            begin
                lead  = hist[esfm_pkg::HALF_WINDOW - 1 - a];
                trail = hist[esfm_pkg::HALF_WINDOW - 1 + c];
                diff  = (lead > trail) ? lead - trail : trail - lead;
                if (diff > peak_next[a + c - 1])
                begin
                    peak_next[a + c - 1] = diff;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int s = 0; s < esfm_pkg::NUM_SUMS; s++)
        begin
            peak[s] = peak_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= in_tok;
            for (int s = 0; s < esfm_pkg::NUM_SUMS; s++)
            begin
                peak_reg[s] <= peak_next[s];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/esfm_divide.sv
`default_nettype none

module esfm_divide (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire esfm_pkg::sample_t peak [esfm_pkg::NUM_SUMS],
    input  wire esfm_pkg::tok_t    in_tok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output esfm_pkg::sample_t      quot [esfm_pkg::NUM_SUMS],
    output esfm_pkg::tok_t         out_tok
);

    logic                        valid_reg, valid_next;
    esfm_pkg::sample_t           quot_reg [esfm_pkg::NUM_SUMS];
    logic [esfm_pkg::PROD_W-1:0] prod     [esfm_pkg::NUM_SUMS];
    esfm_pkg::tok_t              tok_reg;
    logic                        take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    // divide by a+c through a reciprocal multiply; no correction step needed at these widths
    always_comb
    begin
        for (int s = 0; s < esfm_pkg::NUM_SUMS; s++)
        begin
            prod[s] = esfm_pkg::PROD_W'(peak[s]) * esfm_pkg::PROD_W'(esfm_pkg::RECIP[s]);
            quot[s] = quot_reg[s];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= in_tok;
            for (int s = 0; s < esfm_pkg::NUM_SUMS; s++)
            begin
                quot_reg[s] <= prod[s][esfm_pkg::RECIP_SHIFT +: esfm_pkg::SAMPLE_W];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/esfm_output.sv
`default_nettype none

module esfm_output (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire esfm_pkg::sample_t quot [esfm_pkg::NUM_SUMS],
    input  wire esfm_pkg::tok_t    in_tok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output esfm_pkg::col_t         out_col,
    output esfm_pkg::sample_t      out_focus,
    output logic                   out_last
);

    localparam int SPLIT = esfm_pkg::NUM_SUMS / 2;

    logic                         valid_reg, valid_next;
    logic [esfm_pkg::FLUSH_W-1:0] flush_reg, flush_next;
    esfm_pkg::col_t               col_reg, col_next;
    esfm_pkg::sample_t            focus_reg, focus_next;
    logic                         last_reg, last_next;

    esfm_pkg::sample_t best_lo, best_hi, best;
    logic              take;

    assign in_ready  = !valid_reg || (out_ready && flush_reg == '0);
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_col   = col_reg;
    assign out_focus = focus_reg;
    assign out_last  = last_reg;

    // two parallel compare chains, then one final compare
    always_comb
    begin
        best_lo = quot[0];
        best_hi = quot[SPLIT];
        for (int i = 1; i < SPLIT; i++)
        begin
            if (quot[i] > best_lo)
            begin
                best_lo = quot[i];
            end
        end
        for (int i = SPLIT + 1; i < esfm_pkg::NUM_SUMS; i++)
        begin
            if (quot[i] > best_hi)
            begin
                best_hi = quot[i];
            end
        end
        best = (best_hi > best_lo) ? best_hi : best_lo;
    end

    always_comb
    begin
        valid_next = valid_reg;
        flush_next = flush_reg;
        col_next   = col_reg;
        focus_next = focus_reg;
        last_next  = last_reg;

        // advance through the trailing zero columns, or drop the word once taken
        if (valid_reg && out_ready)
        begin
            if (flush_reg != '0)
            begin
                col_next   = col_reg + esfm_pkg::COL_W'(1);
                focus_next = '0;
                last_next  = (flush_reg == esfm_pkg::FLUSH_W'(1));
                flush_next = flush_reg - esfm_pkg::FLUSH_W'(1);
            end
            else
            begin
                valid_next = 1'b0;
            end
        end

        if (take && in_tok.emit)
        begin
            valid_next = 1'b1;
            col_next   = in_tok.col;
            focus_next = in_tok.win ? best : '0;
            last_next  = 1'b0;
            flush_next = in_tok.line_done ? esfm_pkg::FLUSH_W'(esfm_pkg::HALF_WINDOW - 1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flush_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        focus_reg <= focus_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

// File: rtl/esfm_checker.sv
`default_nettype none

module esfm_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [esfm_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                        m_tlast
);

    logic           seen_reg;
    logic           prev_last_reg;
    esfm_pkg::col_t prev_col_reg;
    esfm_pkg::col_t col, expect_col;
    logic           out_fire;

    assign out_fire   = m_tvalid && m_tready;
    assign col        = m_tdata[esfm_pkg::COL_W-1:0];
    assign expect_col = (!seen_reg || prev_last_reg) ? '0
                                                     : prev_col_reg + esfm_pkg::COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_col_reg  <= '0;
        end
        else if (out_fire)
        begin
            seen_reg      <= 1'b1;
            prev_last_reg <= m_tlast;
            prev_col_reg  <= col;
        end
    end

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // columns advance by one and restart at zero after each line end
    a_column_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> col == expect_col)
        else $error("column index out of sequence");

    // the last column of a line lies in the margin
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_tlast |-> m_tdata[esfm_pkg::COL_W +: esfm_pkg::SAMPLE_W] == '0)
        else $error("nonzero focus on line end");

    // no word is offered straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid coming out of reset");

endmodule

bind edge_slope_focus_metric esfm_checker u_esfm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
